@@ design/keyed_record_table_defines.svh @@
// Assertion macros shared by the table design.
// Both sample on clk and are disabled while arst_n is low.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// Property that must hold at every clock edge.
`define KRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property that must hold at every edge where the antecedent is true.
`define KRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/krt_pkg.sv @@
package krt_pkg;

	localparam int KIND_W = 2;
	localparam int KEY_W  = 31;
	localparam int VAL_W  = 16;
	localparam int STAT_W = 2;
	localparam int POS_W  = 5;
	localparam int CNT_W  = 6;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_DELETE = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE,
		S_SHIFT
	} state_t;

	// Command broadcast from the sequencer to every cell of the chain
	typedef struct packed {
		logic cmp;         // compare stored key against the request key
		logic ins;         // write request into the selected free cell
		logic upd;         // replace value of the matching cell
		logic load_mark;   // start the delete marker at the matching cell
		logic shift;       // marked cell takes its right neighbor's record
		logic shift_last;  // final shift step: drop the marker
	} cell_cmd_t;

endpackage

@@ design/krt_cell.sv @@
module krt_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  krt_pkg::cell_cmd_t       cmd,
	input  logic                     ins_sel,
	input  logic [krt_pkg::KEY_W-1:0] op_key,
	input  logic [krt_pkg::VAL_W-1:0] op_val,
	input  logic [krt_pkg::KEY_W-1:0] nxt_key,
	input  logic [krt_pkg::VAL_W-1:0] nxt_val,
	input  logic                     nxt_valid,
	input  logic                     prv_mark,
	output logic [krt_pkg::KEY_W-1:0] cell_key,
	output logic [krt_pkg::VAL_W-1:0] cell_val,
	output logic                     cell_valid,
	output logic                     mark,
	output logic                     match
);
	import krt_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             valid_q;
	logic             mark_q;
	logic             match_q;

	// Record storage: insert, update or pull from the right neighbor
	always_ff @(posedge clk) begin
		if (cmd.ins && ins_sel) begin
			key_q <= op_key;
			val_q <= op_val;
		end else if (cmd.upd && match_q) begin
			val_q <= op_val;
		end else if (cmd.shift && mark_q) begin
			key_q <= nxt_key;
			val_q <= nxt_val;
		end
	end

	// Control bits: occupancy, delete marker and compare result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.ins && ins_sel) begin
				valid_q <= 1'b1;
			end else if (cmd.shift && mark_q) begin
				valid_q <= nxt_valid;
			end

			if (cmd.load_mark) begin
				mark_q <= match_q;
			end else if (cmd.shift) begin
				mark_q <= cmd.shift_last ? 1'b0 : prv_mark;
			end

			if (cmd.cmp) begin
				match_q <= valid_q && (key_q == op_key);
			end
		end
	end

	assign cell_key   = key_q;
	assign cell_val   = val_q;
	assign cell_valid = valid_q;
	assign mark       = mark_q;
	assign match      = match_q;

endmodule

@@ design/krt_ctrl.sv @@
module krt_ctrl #(
	parameter int DEPTH = 32,
	parameter int IW    = 5,
	parameter int CW    = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [krt_pkg::KIND_W-1:0] kind,
	input  logic [krt_pkg::KEY_W-1:0]  key,
	input  logic [krt_pkg::VAL_W-1:0]  value,
	input  logic                       hit,
	input  logic [IW-1:0]              slot,
	input  logic [krt_pkg::VAL_W-1:0]  found,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [krt_pkg::STAT_W-1:0] status,
	output logic [krt_pkg::VAL_W-1:0]  found_value,
	output logic [krt_pkg::POS_W-1:0]  position,
	output logic [krt_pkg::CNT_W-1:0]  entry_count,
	output krt_pkg::cell_cmd_t         cmd,
	output logic [krt_pkg::KEY_W-1:0]  op_key,
	output logic [krt_pkg::VAL_W-1:0]  op_val,
	output logic [CW-1:0]              cnt
);
	import krt_pkg::*;

	localparam int PW = (IW > POS_W) ? IW : POS_W;
	localparam int XW = (CW > CNT_W) ? CW : CNT_W;

	state_t           state_q, state_d;
	kind_t            kind_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic             take;
	logic             load_out;
	status_t          st_d;
	logic [VAL_W-1:0] fnd_d;
	logic [IW-1:0]    pos_d;
	logic [PW-1:0]    pos_ext;
	logic [XW-1:0]    cnt_ext;

	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [VAL_W-1:0]    found_q;
	logic [POS_W-1:0]    position_q;
	logic [CNT_W-1:0]    count_q;

	// Next state, cell commands and result of the current request
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		take     = 1'b0;
		load_out = 1'b0;
		st_d     = ST_OK;
		fnd_d    = '0;
		pos_d    = '0;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					take    = 1'b1;
					state_d = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.cmp = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					if (kind_q == KIND_INSERT) begin
						if (hit) begin
							st_d  = ST_DUP;
							pos_d = slot;
						end else if (cnt_q >= CW'(DEPTH)) begin
							st_d = ST_FULL;
						end else begin
							pos_d   = cnt_q[IW-1:0];
							cmd.ins = 1'b1;
							cnt_d   = cnt_q + 1'b1;
						end
					end else if (!hit) begin
						st_d = ST_MISSING;
					end else begin
						pos_d = slot;
						case (kind_q)
							KIND_LOOKUP: fnd_d = found;
							KIND_UPDATE: cmd.upd = 1'b1;
							KIND_DELETE: begin
								cmd.load_mark = 1'b1;
								cnt_d         = cnt_q - 1'b1;
								idx_d         = slot;
								state_d       = S_SHIFT;
							end
							default: ;
						endcase
					end
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				// cnt_q already holds the reduced count: it is the old last slot
				if (CW'(idx_q) == cnt_q) begin
					cmd.shift_last = 1'b1;
					state_d        = S_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign pos_ext = PW'(pos_d);
	assign cnt_ext = XW'(cnt_d);

	// Sequencer and table count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= kind_t'(kind);
			key_q  <= key;
			val_q  <= value;
		end
	end

	// Output register: load on a finished request, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q   <= st_d;
			found_q    <= fnd_d;
			position_q <= pos_ext[POS_W-1:0];
			count_q    <= cnt_ext[CNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign position    = position_q;
	assign entry_count = count_q;
	assign op_key      = key_q;
	assign op_val      = val_q;
	assign cnt         = cnt_q;

endmodule

@@ design/keyed_record_table.sv @@
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   kind, key, value
// result    out        out_valid/out_stall status, found_value, position, entry_count
//
// Insert, lookup and update go through accept, compare in every cell, decide.
// Delete then shifts the hole along the cell chain, from its slot to the old last slot.
// Reset clears the entry count and every cell's valid bit; no clearing pass.
// A waiting result sits in the output register; the next request is accepted
// meanwhile, and only its decide step waits while out_stall holds the register.
`include "keyed_record_table_defines.svh"

module keyed_record_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [krt_pkg::KIND_W-1:0] kind,
	input  logic [krt_pkg::KEY_W-1:0]  key,
	input  logic [krt_pkg::VAL_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [krt_pkg::STAT_W-1:0] status,
	output logic [krt_pkg::VAL_W-1:0]  found_value,
	output logic [krt_pkg::POS_W-1:0]  position,
	output logic [krt_pkg::CNT_W-1:0]  entry_count
);
	import krt_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	cell_cmd_t        cmd;
	logic [KEY_W-1:0] op_key;
	logic [VAL_W-1:0] op_val;
	logic [CW-1:0]    cnt;

	logic [KEY_W-1:0]     ckey [TABLE_DEPTH];
	logic [VAL_W-1:0]     cval [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cvalid;
	logic [TABLE_DEPTH-1:0] mark;
	logic [TABLE_DEPTH-1:0] match;

	logic             hit;
	logic [IW-1:0]    slot;
	logic [VAL_W-1:0] found;

	krt_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.hit         (hit),
		.slot        (slot),
		.found       (found),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_value (found_value),
		.position    (position),
		.entry_count (entry_count),
		.cmd         (cmd),
		.op_key      (op_key),
		.op_val      (op_val),
		.cnt         (cnt)
	);

	// Chain of cells: each pulls from its right neighbor, marker moves right
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nkey;
		logic [VAL_W-1:0] nval;
		logic             nvalid;
		logic             pmark;

		if (i < TABLE_DEPTH - 1) begin : g_mid
			assign nkey   = ckey[i+1];
			assign nval   = cval[i+1];
			assign nvalid = cvalid[i+1];
		end else begin : g_end
			assign nkey   = '0;
			assign nval   = '0;
			assign nvalid = 1'b0;
		end

		if (i > 0) begin : g_prv
			assign pmark = mark[i-1];
		end else begin : g_first
			assign pmark = 1'b0;
		end

		krt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.ins_sel    (cnt == CW'(i)),
			.op_key     (op_key),
			.op_val     (op_val),
			.nxt_key    (nkey),
			.nxt_val    (nval),
			.nxt_valid  (nvalid),
			.prv_mark   (pmark),
			.cell_key   (ckey[i]),
			.cell_val   (cval[i]),
			.cell_valid (cvalid[i]),
			.mark       (mark[i]),
			.match      (match[i])
		);
	end

	// Keys are unique among valid cells, so at most one cell matches: OR it down
	always_comb begin
		hit   = |match;
		slot  = '0;
		found = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match[i]) begin
				slot  = slot | IW'(i);
				found = found | cval[i];
			end
		end
	end

	`KRT_ASSERT(a_match_unique, $onehot0(match), "more than one cell matched the key")
	`KRT_ASSERT(a_count_bound, cnt <= CW'(TABLE_DEPTH), "entry count above table depth")
	`KRT_ASSERT_IMP(a_valid_count, !in_stall, $countones(cvalid) == int'(cnt), "valid cells disagree with entry count")

endmodule

@@ sim/keyed_record_table_tb.sv @@
module keyed_record_table_tb;
	import krt_pkg::*;

	localparam int DEPTH      = 32;
	localparam int HOLD_LEN   = 120;
	localparam int HOLD_AT    = 300;
	localparam int RAND_COUNT = 1080;
	localparam int TAIL_WAIT  = 60;
	localparam int IDLE_LIMIT = 2000;

	// one result of a table operation
	typedef struct {
		status_t         st;
		logic [VAL_W-1:0] found;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} op_result_t;

	// one directed request, with its result typed in where it is obvious
	typedef struct {
		kind_t            op;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		bit               typed;
		status_t          st;
		logic [VAL_W-1:0] found;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} script_row_t;

	typedef enum int {
		MIX_FILL,
		MIX_EVEN,
		MIX_DRAIN
	} mix_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [KEY_W-1:0]    key;
	logic [VAL_W-1:0]    value;
	logic                out_valid;
	logic                out_stall;
	logic [STAT_W-1:0]   status;
	logic [VAL_W-1:0]    found_value;
	logic [POS_W-1:0]    position;
	logic [CNT_W-1:0]    entry_count;

	// mirror of the table contents
	logic [KEY_W-1:0] mirror_keys [DEPTH];
	logic [VAL_W-1:0] mirror_vals [DEPTH];
	int               mirror_count;

	op_result_t awaited_results [$];
	int         error_count   = 0;
	int         results_seen  = 0;
	int         idle_cycles   = 0;
	bit         sender_calm;
	bit         receiver_calm = 1'b0;

	script_row_t script [0:19] = '{
		'{KIND_LOOKUP, 31'h0,        16'h0,    1'b1, ST_MISSING, 16'h0,    5'd0, 6'd0},
		'{KIND_DELETE, 31'h0,        16'h0,    1'b1, ST_MISSING, 16'h0,    5'd0, 6'd0},
		'{KIND_UPDATE, 31'h0,        16'h1,    1'b1, ST_MISSING, 16'h0,    5'd0, 6'd0},
		'{KIND_INSERT, 31'h0,        16'hFFFF, 1'b1, ST_OK,      16'h0,    5'd0, 6'd1},
		'{KIND_INSERT, 31'h7FFFFFFF, 16'h0,    1'b1, ST_OK,      16'h0,    5'd1, 6'd2},
		'{KIND_INSERT, 31'h0,        16'h1,    1'b1, ST_DUP,     16'h0,    5'd0, 6'd2},
		'{KIND_LOOKUP, 31'h0,        16'h0,    1'b1, ST_OK,      16'hFFFF, 5'd0, 6'd2},
		'{KIND_LOOKUP, 31'h7FFFFFFF, 16'hFFFF, 1'b1, ST_OK,      16'h0,    5'd1, 6'd2},
		'{KIND_UPDATE, 31'h7FFFFFFF, 16'h1234, 1'b1, ST_OK,      16'h0,    5'd1, 6'd2},
		'{KIND_LOOKUP, 31'h7FFFFFFF, 16'h0,    1'b1, ST_OK,      16'h1234, 5'd1, 6'd2},
		'{KIND_DELETE, 31'h0,        16'h0,    1'b1, ST_OK,      16'h0,    5'd0, 6'd1},
		'{KIND_LOOKUP, 31'h7FFFFFFF, 16'h0,    1'b1, ST_OK,      16'h1234, 5'd0, 6'd1},
		'{KIND_LOOKUP, 31'h0,        16'h0,    1'b1, ST_MISSING, 16'h0,    5'd0, 6'd1},
		'{KIND_DELETE, 31'h7FFFFFFF, 16'h0,    1'b1, ST_OK,      16'h0,    5'd0, 6'd0},
		'{KIND_LOOKUP, 31'h7FFFFFFF, 16'h0,    1'b1, ST_MISSING, 16'h0,    5'd0, 6'd0},
		'{KIND_INSERT, 31'h2AAAAAAA, 16'h5555, 1'b0, ST_OK,      16'h0,    5'd0, 6'd0},
		'{KIND_INSERT, 31'h55555555, 16'hAAAA, 1'b0, ST_OK,      16'h0,    5'd0, 6'd0},
		'{KIND_INSERT, 31'h00000001, 16'h0100, 1'b0, ST_OK,      16'h0,    5'd0, 6'd0},
		'{KIND_DELETE, 31'h55555555, 16'h0,    1'b0, ST_OK,      16'h0,    5'd0, 6'd0},
		'{KIND_LOOKUP, 31'h00000001, 16'h0,    1'b0, ST_OK,      16'h0,    5'd0, 6'd0}
	};

	keyed_record_table #(.TABLE_DEPTH(DEPTH)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_value (found_value),
		.position    (position),
		.entry_count (entry_count)
	);

	always #1 clk = ~clk;

	// apply one operation to the mirror and return its result
	function automatic op_result_t table_apply(kind_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		op_result_t r;
		int         hit;
		r.st    = ST_OK;
		r.found = '0;
		r.pos   = '0;
		hit     = -1;
		for (int i = 0; i < mirror_count; i++) begin
			if (hit < 0 && mirror_keys[i] == k) begin
				hit = i;
			end
		end
		if (op == KIND_INSERT) begin
			if (hit >= 0) begin
				r.st  = ST_DUP;
				r.pos = hit[POS_W-1:0];
			end else if (mirror_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				r.pos                     = mirror_count[POS_W-1:0];
				mirror_keys[mirror_count] = k;
				mirror_vals[mirror_count] = v;
				mirror_count++;
			end
		end else if (hit < 0) begin
			r.st = ST_MISSING;
		end else begin
			r.pos = hit[POS_W-1:0];
			case (op)
				KIND_LOOKUP: begin
					r.found = mirror_vals[hit];
				end
				KIND_UPDATE: begin
					mirror_vals[hit] = v;
				end
				default: begin
					// close the hole and clear the freed last slot
					for (int j = hit; j + 1 < mirror_count; j++) begin
						mirror_keys[j] = mirror_keys[j + 1];
						mirror_vals[j] = mirror_vals[j + 1];
					end
					mirror_keys[mirror_count - 1] = '0;
					mirror_vals[mirror_count - 1] = '0;
					mirror_count--;
				end
			endcase
		end
		r.count = mirror_count[CNT_W-1:0];
		return r;
	endfunction

	// offer one request, wait for acceptance, then record its expected result
	task automatic offer(kind_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			bit typed, op_result_t typed_res);
		int         gap;
		op_result_t predicted;
		if ($urandom_range(0, 39) == 0) begin
			sender_calm = !sender_calm;
		end
		gap = sender_calm ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind     <= op;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (in_stall);
		predicted = table_apply(op, k, v);
		awaited_results.push_back(typed ? typed_res : predicted);
	endtask

	// receive results, stalling at random, and check them in order
	initial begin
		int         gap;
		bit         held;
		op_result_t exp;
		held      = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			// hold off once for a long stretch so the block fills up
			if (results_seen == HOLD_AT && !held) begin
				held = 1'b1;
				repeat (HOLD_LEN) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			if ($urandom_range(0, 39) == 0) begin
				receiver_calm = !receiver_calm;
			end
			gap = receiver_calm ? 0 : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited: status %h value %h pos %h count %h",
					$time, status, found_value, position, entry_count);
				error_count++;
			end else begin
				exp = awaited_results.pop_front();
				if (status !== exp.st) begin
					$display("%0t: status expected %h actual %h", $time, exp.st, status);
					error_count++;
				end
				if (found_value !== exp.found) begin
					$display("%0t: found_value expected %h actual %h",
						$time, exp.found, found_value);
					error_count++;
				end
				if (position !== exp.pos) begin
					$display("%0t: position expected %h actual %h", $time, exp.pos, position);
					error_count++;
				end
				if (entry_count !== exp.count) begin
					$display("%0t: entry_count expected %h actual %h",
						$time, exp.count, entry_count);
					error_count++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("keyed_record_table_tb: errors");
			$finish;
		end
	end

	initial begin
		op_result_t       typed_res;
		op_result_t       unused_res;
		mix_t             mix;
		kind_t            op;
		logic [KEY_W-1:0] k;
		int               pick;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = '0;
		key           = '0;
		value         = '0;
		sender_calm   = 1'b0;
		mirror_count  = 0;
		unused_res    = '{ST_OK, '0, '0, '0};
		for (int i = 0; i < DEPTH; i++) begin
			mirror_keys[i] = '0;
			mirror_vals[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed script
		foreach (script[i]) begin
			typed_res = '{script[i].st, script[i].found, script[i].pos, script[i].count};
			offer(script[i].op, script[i].k, script[i].v, script[i].typed, typed_res);
		end

		// random requests in phases that fill, mix and drain the table
		mix = MIX_FILL;
		for (int n = 0; n < RAND_COUNT; n++) begin
			if (n % 90 == 0) begin
				mix = (n / 90) % 3 == 0 ? MIX_FILL : ((n / 90) % 3 == 1 ? MIX_EVEN : MIX_DRAIN);
			end
			pick = $urandom_range(0, 99);
			case (mix)
				MIX_FILL: begin
					op = pick < 70 ? KIND_INSERT : (pick < 80 ? KIND_LOOKUP :
						(pick < 90 ? KIND_UPDATE : KIND_DELETE));
				end
				MIX_EVEN: begin
					op = kind_t'(pick % 4);
				end
				default: begin
					op = pick < 15 ? KIND_INSERT : (pick < 35 ? KIND_LOOKUP :
						(pick < 45 ? KIND_UPDATE : KIND_DELETE));
				end
			endcase
			// mostly present keys, some small and extreme ones, the rest noise
			pick = $urandom_range(0, 99);
			if (mirror_count > 0 && pick < 55) begin
				k = mirror_keys[$urandom_range(0, mirror_count - 1)];
			end else if (pick < 72) begin
				k = KEY_W'($urandom_range(0, 40));
			end else if (pick < 76) begin
				k = '1;
			end else begin
				k = KEY_W'($urandom);
			end
			offer(op, k, VAL_W'($urandom), 1'b0, unused_res);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain and let any stray result show up
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (error_count == 0) begin
			$display("keyed_record_table_tb: clean");
		end else begin
			$display("keyed_record_table_tb: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/krt_pkg.sv
design/krt_cell.sv
design/krt_ctrl.sv
design/keyed_record_table.sv
sim/keyed_record_table_tb.sv
